/* design/osr_pkg.sv */
// Package for the ordered set with rank: command/result words, status codes,
// cell control struct and sizing constants. No dependencies.
package osr_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_W        = 32;
  localparam int RANK_W       = 9;
  localparam int GROUP        = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_RANK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [RANK_W-1:0] rank;
  } out_word_t;

  typedef struct packed {
    logic                    cmp;
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

/* design/osr_cell.sv */
// One slot of the sorted chain: holds a key and its valid bit, compares
// against the broadcast key and shifts with its neighbors. Uses osr_pkg.
module osr_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  osr_pkg::cell_ctl_t              ctl,
  input  logic signed [osr_pkg::KEY_W-1:0] left_key,
  input  logic                            left_valid,
  input  logic                            left_lt,
  input  logic signed [osr_pkg::KEY_W-1:0] right_key,
  input  logic                            right_valid,
  output logic signed [osr_pkg::KEY_W-1:0] key,
  output logic                            valid,
  output logic                            lt,
  output logic                            eq
);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= valid && (key < ctl.key);
      eq <= valid && (key == ctl.key);
    end
    if (ctl.ins && !lt) begin
      key <= left_lt ? ctl.key : left_key;
    end else if (ctl.rem && !lt) begin
      key <= right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      valid <= valid | left_valid;
    end else if (ctl.rem && !lt) begin
      valid <= right_valid;
    end
  end

endmodule

/* design/osr_reduce.sv */
// Two-level reduction of the per-cell match flags into found and rank.
// Groups are registered; the final merge is combinational. Uses osr_pkg.
module osr_reduce #(
  parameter int CAPACITY = osr_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [CAPACITY-1:0]         eq,
  output logic                        found,
  output logic [osr_pkg::RANK_W-1:0]  rank
);

  localparam int NGRP = (CAPACITY + osr_pkg::GROUP - 1) / osr_pkg::GROUP;

  logic [NGRP-1:0]                      grp_found, grp_found_next;
  logic [osr_pkg::RANK_W-1:0]           grp_rank [NGRP];
  logic [osr_pkg::RANK_W-1:0]           grp_rank_next [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_found_next[g] = 1'b0;
      grp_rank_next[g]  = '0;
      for (int j = 0; j < osr_pkg::GROUP; j++) begin
        if (g * osr_pkg::GROUP + j < CAPACITY) begin
          if (eq[g * osr_pkg::GROUP + j]) begin
            grp_found_next[g] = 1'b1;
            grp_rank_next[g]  = grp_rank_next[g] |
                                osr_pkg::RANK_W'(g * osr_pkg::GROUP + j + 1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_found <= grp_found_next;
      grp_rank  <= grp_rank_next;
    end
  end

  always_comb begin
    found = |grp_found;
    rank  = '0;
    for (int g = 0; g < NGRP; g++) begin
      rank = rank | grp_rank[g];
    end
  end

endmodule

/* design/ordered_set_with_rank.sv */
// Top level of the ordered set with rank: sequencer, chain of slot cells
// and match reduction. Uses osr_pkg, osr_cell, osr_reduce.
//
// Usage:
//   A command word (operation, key) is taken at a rising edge with start
//   high and busy low. busy stays high while the command is worked on.
//   Exactly one result word (status, rank) is shown on result for one
//   cycle with done high; the receiver must take it then.
//   done is high after the states S_CMP, S_GRP and S_FIN, registered from S_FIN;
//   busy drops in that same cycle, so a new command may be taken at the
//   edge that ends it. No new command is taken while one is worked on.
//   The steps are: compare in every cell, registered match reduction over
//   groups of 16 cells, final merge with the shift of the chain, result.
//   Insert and remove move every cell at or above the insertion point by
//   one slot toward its neighbor, all together in the final merge step.
//   Reset (rst, synchronous) empties the set: valid bits and the key count
//   clear, key storage is left as is. No clearing pass is needed.
//   The receiver cannot stall; results are never held back.
module ordered_set_with_rank #(
  parameter int CAPACITY = osr_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  osr_pkg::in_word_t  cmd,
  output logic               busy,
  output logic               done,
  output osr_pkg::out_word_t result
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_GRP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                           state, state_next;
  logic [1:0]                       op;
  logic signed [osr_pkg::KEY_W-1:0] key;
  logic [CW-1:0]                    count;
  osr_pkg::cell_ctl_t               ctl;
  logic                             found;
  logic [osr_pkg::RANK_W-1:0]       found_rank;
  osr_pkg::out_word_t               result_next;
  logic                             do_ins, do_rem;

  logic signed [osr_pkg::KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]              cell_valid, cell_lt, cell_eq;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_CMP;
      S_CMP:   state_next = S_GRP;
      S_GRP:   state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op  <= cmd.operation;
      key <= cmd.key;
    end
  end

  always_comb begin
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    result_next = '{status: osr_pkg::ST_DONE, rank: '0};
    case (op)
      osr_pkg::OP_INSERT: begin
        if (found) begin
          result_next.status = osr_pkg::ST_DUP;
        end else if (count == CW'(CAPACITY)) begin
          result_next.status = osr_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      osr_pkg::OP_RANK: begin
        if (found) begin
          result_next.rank = found_rank;
        end else begin
          result_next.status = osr_pkg::ST_ABSENT;
        end
      end
      osr_pkg::OP_REMOVE: begin
        if (found) begin
          do_rem = 1'b1;
        end else begin
          result_next.status = osr_pkg::ST_ABSENT;
        end
      end
      default: result_next.status = osr_pkg::ST_DONE;
    endcase
  end

  always_comb begin
    ctl.cmp = (state == S_CMP);
    ctl.ins = (state == S_FIN) && do_ins;
    ctl.rem = (state == S_FIN) && do_rem;
    ctl.key = key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      if (ctl.ins) begin
        count <= count + CW'(1);
      end else if (ctl.rem) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      result <= result_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [osr_pkg::KEY_W-1:0] lk, rk;
    logic                             lv, ll, rv;
    if (i == 0) begin : g_first
      assign lk = cell_key[i];
      assign lv = 1'b1;
      assign ll = 1'b1;
    end else begin : g_mid_l
      assign lk = cell_key[i-1];
      assign lv = cell_valid[i-1];
      assign ll = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rk = cell_key[i];
      assign rv = 1'b0;
    end else begin : g_mid_r
      assign rk = cell_key[i+1];
      assign rv = cell_valid[i+1];
    end
    osr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_key    (lk),
      .left_valid  (lv),
      .left_lt     (ll),
      .right_key   (rk),
      .right_valid (rv),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i])
    );
  end

  osr_reduce #(
    .CAPACITY (CAPACITY)
  ) u_reduce (
    .clk   (clk),
    .load  (state == S_GRP),
    .eq    (cell_eq),
    .found (found),
    .rank  (found_rank)
  );

endmodule

/* design/osr_checker.sv */
// Port-level checker for ordered_set_with_rank, bound to the top level.
// Uses osr_pkg.
module osr_port_assert (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input osr_pkg::out_word_t result
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("result word not delivered four cycles after command");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("done outside end of command");

  a_rank_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.rank != '0) |-> (result.status == osr_pkg::ST_DONE))
    else $error("rank given with failing status");

endmodule

bind ordered_set_with_rank osr_port_assert u_osr_port_assert (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
